### design/pita_pkg.sv
`timescale 1ns / 1ps
// Package for the padded integer to ASCII formatter: beat types, radix codes,
// ASCII constants and the digit helper functions. It depends on nothing else.
package pita_pkg;

    localparam int CALC_W      = 32;
    localparam int STORE_DEPTH = 32;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int DIGIT_W     = 4;
    localparam int RECIP_SHIFT = 35;

    localparam logic [CALC_W-1:0] RECIP10 = 32'hCCCC_CCCD;

    localparam logic [1:0] BASE_BIN = 2'd0;
    localparam logic [1:0] BASE_OCT = 2'd1;
    localparam logic [1:0] BASE_DEC = 2'd2;
    localparam logic [1:0] BASE_HEX = 2'd3;

    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

    typedef struct packed {
        logic [31:0] magnitude;
        logic        negative;
        logic [1:0]  base_select;
        logic [6:0]  field_width;
        logic        left_adjust;
        logic        zero_pad;
        logic        upper_case;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } t_out_beat;

    function automatic logic [2:0] base_shift(input logic [1:0] base);
        logic [2:0] sh;
        case (base)
            BASE_BIN: sh = 3'd1;
            BASE_OCT: sh = 3'd3;
            default:  sh = 3'd4;
        endcase
        return sh;
    endfunction

    function automatic logic [DIGIT_W-1:0] base_mask(input logic [1:0] base);
        logic [DIGIT_W-1:0] m;
        case (base)
            BASE_BIN: m = 4'h1;
            BASE_OCT: m = 4'h7;
            default:  m = 4'hF;
        endcase
        return m;
    endfunction

    function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d,
                                              input logic upper);
        logic [7:0] ch;
        if (d <= DIGIT_MAX) begin
            ch = CH_ZERO + {4'b0, d};
        end else begin
            ch = (upper ? CH_UPPER_A : CH_LOWER_A) + {4'b0, d} - 8'd10;
        end
        return ch;
    endfunction

endpackage

### design/pita_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// It depends on nothing else.
module pita_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/pita_digit_unit.sv
`timescale 1ns / 1ps
// Shared digit unit: registers a value and radix on load, then splits it into
// quotient and lowest digit for the selected radix. It depends on pita_pkg.
module pita_digit_unit #(
    parameter int VALUE_W = 32
) (
    input  logic                        i_clk,
    input  logic                        i_load,
    input  logic [VALUE_W-1:0]          i_value,
    input  logic [1:0]                  i_base,
    output logic [VALUE_W-1:0]          o_quot,
    output logic [pita_pkg::DIGIT_W-1:0] o_rem
);
    import pita_pkg::*;

    logic [CALC_W-1:0]   r_val;
    logic [2*CALC_W-1:0] r_prod;
    logic [1:0]          r_base;

    logic [CALC_W-1:0] quot;
    logic [CALC_W-1:0] diff;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_val  <= CALC_W'(i_value);
            r_prod <= (2*CALC_W)'(CALC_W'(i_value)) * (2*CALC_W)'(RECIP10);
            r_base <= i_base;
        end
    end

    // The decimal quotient comes from the reciprocal product; the others shift.
    always_comb begin
        if (r_base == BASE_DEC) begin
            quot  = CALC_W'(r_prod >> RECIP_SHIFT);
            diff  = r_val - ((quot << 3) + (quot << 1));
            o_rem = diff[DIGIT_W-1:0];
        end else begin
            quot  = r_val >> base_shift(r_base);
            diff  = r_val;
            o_rem = diff[DIGIT_W-1:0] & base_mask(r_base);
        end
    end

    assign o_quot = quot[VALUE_W-1:0];

endmodule

### design/padded_integer_to_ascii.sv
`timescale 1ns / 1ps
// Padded integer to ASCII formatter, top level: sequencer, digit store and
// output register. It depends on pita_pkg, pita_ram and pita_digit_unit.
//
// A field request is accepted at a rising edge with start high and busy low.
// The block then splits the value into digits, each through the shared digit
// unit in S_DIV_A and S_DIV_B, and lays out the field in S_PREP. After
// that it emits one character per cycle, most significant first, each beat
// on o_result for exactly one cycle with o_strobe high; the final beat of
// the field carries last. The receiver cannot stall, so beats are never held.
// Busy falls while the final beat is still on the output, so a new request
// may be taken then. For D digits and a field of T characters, D is at most
// 32 (binary) and 10 (decimal) and T at most 64.
// Reset clears the sequencer and the strobe; the digit store is not cleared,
// since each field writes every digit before reading it.
module padded_integer_to_ascii #(
    parameter int VALUE_BITS = 32,
    parameter int MAX_WIDTH  = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  pita_pkg::t_in_beat   i_item,
    output logic                 busy,
    output logic                 o_strobe,
    output pita_pkg::t_out_beat  o_result
);
    import pita_pkg::*;

    localparam int VALUE_W = (VALUE_BITS < CALC_W) ? VALUE_BITS : CALC_W;
    localparam logic [6:0] MAX_W = 7'(MAX_WIDTH);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV_A = 3'd1;
    localparam logic [2:0] S_DIV_B = 3'd2;
    localparam logic [2:0] S_PREP  = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0]          r_state,    n_state;
    logic [VALUE_W-1:0]  r_value,    n_value;
    logic [5:0]          r_count,    n_count;
    logic [6:0]          r_emit,     n_emit;
    logic [STORE_AW-1:0] r_rd_idx,   n_rd_idx;
    logic [6:0]          r_sign_pos, n_sign_pos;
    logic [6:0]          r_dig_start, n_dig_start;
    logic [6:0]          r_dig_end,  n_dig_end;
    logic [6:0]          r_last_pos, n_last_pos;
    logic                r_strobe,   n_strobe;
    t_out_beat           r_result,   n_result;

    logic       r_neg, r_left, r_zpad, r_upper;
    logic [1:0] r_base;
    logic [6:0] r_width;

    logic                 accept;
    logic                 unit_load;
    logic [VALUE_W-1:0]   unit_quot;
    logic [DIGIT_W-1:0]   unit_rem;
    logic                 st_we;
    logic [DIGIT_W-1:0]   st_rdata;

    logic [6:0] actual;
    logic [6:0] total;
    logic [6:0] pad;

    assign accept    = start && !busy;
    assign busy      = (r_state != S_IDLE);
    assign unit_load = (r_state == S_DIV_A);
    assign st_we     = (r_state == S_DIV_B);

    pita_digit_unit #(
        .VALUE_W (VALUE_W)
    ) u_digit (
        .i_clk   (i_clk),
        .i_load  (unit_load),
        .i_value (r_value),
        .i_base  (r_base),
        .o_quot  (unit_quot),
        .o_rem   (unit_rem)
    );

    pita_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (r_count[STORE_AW-1:0]),
        .i_wdata (unit_rem),
        .i_raddr (n_rd_idx),
        .o_rdata (st_rdata)
    );

    always_comb begin
        actual = {1'b0, r_count} + {6'b0, r_neg};
        total  = (r_width > actual) ? r_width : actual;
        pad    = total - actual;
    end

    always_comb begin
        n_state     = r_state;
        n_value     = r_value;
        n_count     = r_count;
        n_emit      = r_emit;
        n_rd_idx    = r_rd_idx;
        n_sign_pos  = r_sign_pos;
        n_dig_start = r_dig_start;
        n_dig_end   = r_dig_end;
        n_last_pos  = r_last_pos;
        n_strobe    = 1'b0;
        n_result    = r_result;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_DIV_A;
                    n_value = i_item.magnitude[VALUE_W-1:0];
                    n_count = '0;
                end
            end
            S_DIV_A: begin
                n_state = S_DIV_B;
            end
            S_DIV_B: begin
                n_value  = unit_quot;
                n_count  = r_count + 6'd1;
                n_rd_idx = r_count[STORE_AW-1:0];
                if (unit_quot == '0 || r_count == 6'(STORE_DEPTH - 1)) begin
                    n_state = S_PREP;
                end else begin
                    n_state = S_DIV_A;
                end
            end
            S_PREP: begin
                n_state    = S_EMIT;
                n_emit     = '0;
                n_last_pos = total - 7'd1;
                if (!r_left && !r_zpad) begin
                    n_sign_pos  = pad;
                    n_dig_start = pad + {6'b0, r_neg};
                end else if (r_left) begin
                    n_sign_pos  = '0;
                    n_dig_start = {6'b0, r_neg};
                end else begin
                    n_sign_pos  = '0;
                    n_dig_start = {6'b0, r_neg} + pad;
                end
                n_dig_end = n_dig_start + {1'b0, r_count};
            end
            S_EMIT: begin
                n_strobe      = 1'b1;
                n_result.last = (r_emit == r_last_pos);
                if (r_emit < r_dig_start) begin
                    if (r_neg && r_emit == r_sign_pos) begin
                        n_result.character = CH_MINUS;
                    end else if (r_zpad && !r_left) begin
                        n_result.character = CH_ZERO;
                    end else begin
                        n_result.character = CH_SPACE;
                    end
                end else if (r_emit < r_dig_end) begin
                    n_result.character = digit_char(st_rdata, r_upper);
                    if (r_rd_idx != '0) begin
                        n_rd_idx = r_rd_idx - STORE_AW'(1);
                    end
                end else begin
                    n_result.character = CH_SPACE;
                end
                n_emit = r_emit + 7'd1;
                if (r_emit == r_last_pos) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_emit   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_emit   <= n_emit;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value     <= n_value;
        r_rd_idx    <= n_rd_idx;
        r_sign_pos  <= n_sign_pos;
        r_dig_start <= n_dig_start;
        r_dig_end   <= n_dig_end;
        r_last_pos  <= n_last_pos;
        r_result    <= n_result;
        if (accept) begin
            r_neg   <= i_item.negative;
            r_base  <= i_item.base_select;
            r_width <= (i_item.field_width > MAX_W) ? MAX_W : i_item.field_width;
            r_left  <= i_item.left_adjust;
            r_zpad  <= i_item.zero_pad;
            r_upper <= i_item.upper_case;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // A beat only ever leaves the cycle after an emit cycle.
    a_strobe_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == S_EMIT))
        else $error("beat without an emit cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy && r_count == '0)
        else $error("accepted request did not start the digit loop");

    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.last) |=> !o_strobe)
        else $error("beat follows the end of a field");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 6'(STORE_DEPTH))
        else $error("digit count beyond the store");

    a_emit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_emit <= r_last_pos && r_last_pos < 7'(MAX_WIDTH + 1)))
        else $error("emit index past the end of the field");

endmodule

### tb/pita_checker.sv
`timescale 1ns / 1ps
// Checker for the padded integer to ASCII formatter: it watches both beat channels,
// predicts every formatted field and compares each character beat in order.
// It depends on pita_pkg for the beat types, radix codes and ASCII constants.
module pita_checker #(
    parameter int MAX_WIDTH = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_busy,
    input  pita_pkg::t_in_beat  i_item,
    input  logic                i_strobe,
    input  pita_pkg::t_out_beat i_result,
    output int                  o_fail_count,
    output int                  o_pending
);
    import pita_pkg::*;

    t_out_beat expected_chars[$];
    t_out_beat oldest;

    function automatic logic [7:0] digit_to_ascii(input logic [3:0] d, input logic upper);
        if (d <= DIGIT_MAX) begin
            return CH_ZERO + {4'b0, d};
        end
        return (upper ? CH_UPPER_A : CH_LOWER_A) + ({4'b0, d} - 8'd10);
    endfunction

    task automatic format_field(input t_in_beat req);
        logic [3:0]  digits[STORE_DEPTH];
        logic [7:0]  chars[$];
        logic [31:0] val;
        int          radix;
        int          n_digits;
        int          width;
        int          body;
        int          pad;
        t_out_beat   beat;
        case (req.base_select)
            BASE_BIN: radix = 2;
            BASE_OCT: radix = 8;
            BASE_DEC: radix = 10;
            default:  radix = 16;
        endcase
        val = req.magnitude;
        n_digits = 0;
        do begin
            digits[n_digits] = 4'(val % radix);
            val = val / radix;
            n_digits++;
        end while (val != 0 && n_digits < STORE_DEPTH);
        width = (int'(req.field_width) > MAX_WIDTH) ? MAX_WIDTH : int'(req.field_width);
        body  = n_digits + (req.negative ? 1 : 0);
        pad   = (width > body) ? width - body : 0;
        if (!req.left_adjust && !req.zero_pad) begin
            repeat (pad) chars.push_back(CH_SPACE);
        end
        if (req.negative) begin
            chars.push_back(CH_MINUS);
        end
        if (!req.left_adjust && req.zero_pad) begin
            repeat (pad) chars.push_back(CH_ZERO);
        end
        for (int i = n_digits - 1; i >= 0; i--) begin
            chars.push_back(digit_to_ascii(digits[i], req.upper_case));
        end
        if (req.left_adjust) begin
            repeat (pad) chars.push_back(CH_SPACE);
        end
        foreach (chars[i]) begin
            beat.character = chars[i];
            beat.last      = (i == chars.size() - 1);
            expected_chars.push_back(beat);
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_strobe) begin
                if (expected_chars.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, actual char %h last %b",
                             $time, i_result.character, i_result.last);
                    o_fail_count++;
                end else begin
                    oldest = expected_chars.pop_front();
                    if (i_result.character !== oldest.character) begin
                        $display("%0t: character mismatch, expected %h, actual %h",
                                 $time, oldest.character, i_result.character);
                        o_fail_count++;
                    end
                    if (i_result.last !== oldest.last) begin
                        $display("%0t: last mismatch, expected %b, actual %b",
                                 $time, oldest.last, i_result.last);
                        o_fail_count++;
                    end
                end
            end
            if (i_start && i_busy === 1'b0) begin
                format_field(i_item);
            end
        end
        o_pending = expected_chars.size();
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// Top of the formatter testbench: clock, reset, field requests and the verdict.
// It depends on pita_pkg, pita_checker and the padded_integer_to_ascii block.
module tb_top;
    import pita_pkg::*;

    localparam int IDLE_LIMIT = 2000;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    t_in_beat  i_item;
    logic      busy;
    logic      o_strobe;
    t_out_beat o_result;
    int        fail_count;
    int        pending;
    int        idle_cycles;
    int        idle_pct;

    padded_integer_to_ascii u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    pita_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (i_item),
        .i_strobe     (o_strobe),
        .i_result     (o_result),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && busy === 1'b0) || o_strobe) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    function automatic t_in_beat make_field(input logic [31:0] mag, input logic neg,
                                            input logic [1:0] base, input logic [6:0] width,
                                            input logic left, input logic zpad,
                                            input logic upper);
        t_in_beat req;
        req.magnitude   = mag;
        req.negative    = neg;
        req.base_select = base;
        req.field_width = width;
        req.left_adjust = left;
        req.zero_pad    = zpad;
        req.upper_case  = upper;
        return req;
    endfunction

    function automatic t_in_beat random_field();
        t_in_beat   req;
        logic [31:0] mag;
        case ($urandom_range(3))
            0: mag = $urandom;
            1: mag = $urandom_range(0, 20);
            2: mag = $urandom >> $urandom_range(31);
            default: begin
                case ($urandom_range(2))
                    0: mag = '0;
                    1: mag = '1;
                    default: mag = 32'd1 << $urandom_range(31);
                endcase
            end
        endcase
        req = make_field(mag, 1'($urandom), 2'($urandom), 7'($urandom_range(0, 24)),
                         1'($urandom), 1'($urandom), 1'($urandom));
        if ($urandom_range(9) < 3) begin
            req.field_width = 7'($urandom_range(0, 127));
        end
        return req;
    endfunction

    task automatic drain();
        start <= 1'b0;
        @(negedge i_clk);
        while (pending != 0 || busy !== 1'b0) @(negedge i_clk);
    endtask

    task automatic send_field(input t_in_beat req);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        while (busy !== 1'b0) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start  <= 1'b1;
        i_item <= req;
        @(negedge i_clk);
    endtask

    initial begin
        i_rst_n  = 1'b0;
        start    = 1'b0;
        i_item   = '0;
        idle_pct = 11;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        send_field(make_field(32'd0, 1'b0, BASE_DEC, 7'd0, 1'b0, 1'b0, 1'b0));
        send_field(make_field(32'd0, 1'b1, BASE_DEC, 7'd5, 1'b0, 1'b1, 1'b0));
        send_field(make_field(32'hFFFF_FFFF, 1'b0, BASE_BIN, 7'd0, 1'b0, 1'b0, 1'b0));
        send_field(make_field(32'hFFFF_FFFF, 1'b1, BASE_BIN, 7'd64, 1'b1, 1'b0, 1'b0));
        send_field(make_field(32'hFFFF_FFFF, 1'b0, BASE_OCT, 7'd20, 1'b0, 1'b1, 1'b0));
        send_field(make_field(32'hFFFF_FFFF, 1'b1, BASE_DEC, 7'd127, 1'b0, 1'b0, 1'b0));
        send_field(make_field(32'hFFFF_FFFF, 1'b0, BASE_HEX, 7'd10, 1'b0, 1'b0, 1'b1));
        send_field(make_field(32'hDEAD_BEEF, 1'b0, BASE_HEX, 7'd12, 1'b0, 1'b1, 1'b0));
        send_field(make_field(32'hABCD_EF01, 1'b1, BASE_HEX, 7'd65, 1'b0, 1'b1, 1'b1));
        send_field(make_field(32'd12345, 1'b1, BASE_DEC, 7'd2, 1'b0, 1'b1, 1'b0));
        send_field(make_field(32'd12345, 1'b0, BASE_DEC, 7'd10, 1'b1, 1'b1, 1'b0));
        send_field(make_field(32'd12345, 1'b1, BASE_DEC, 7'd10, 1'b1, 1'b0, 1'b0));
        send_field(make_field(32'd7, 1'b0, BASE_OCT, 7'd1, 1'b0, 1'b0, 1'b0));
        send_field(make_field(32'd8, 1'b1, BASE_OCT, 7'd64, 1'b0, 1'b1, 1'b0));
        send_field(make_field(32'h8000_0000, 1'b0, BASE_BIN, 7'd33, 1'b0, 1'b1, 1'b0));
        send_field(make_field(32'd1, 1'b0, BASE_BIN, 7'd64, 1'b0, 1'b0, 1'b1));
        send_field(make_field(32'd9, 1'b0, BASE_DEC, 7'd63, 1'b1, 1'b0, 1'b0));
        send_field(make_field(32'd10, 1'b0, BASE_HEX, 7'd3, 1'b0, 1'b0, 1'b0));
        send_field(make_field(32'd15, 1'b1, BASE_HEX, 7'd4, 1'b0, 1'b1, 1'b1));
        send_field(make_field(32'd0, 1'b0, BASE_HEX, 7'd127, 1'b1, 1'b1, 1'b1));
        send_field(make_field(32'h5555_5555, 1'b1, BASE_BIN, 7'd100, 1'b0, 1'b1, 1'b0));
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 11 : (phase == 1) ? 47 : 0;
            for (int n = 0; n < 150; n++) begin
                if ($urandom_range(39) == 0) begin
                    drain();
                end
                send_field(random_field());
            end
            drain();
        end

        repeat (10) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### sim.f
design/pita_pkg.sv
design/pita_ram.sv
design/pita_digit_unit.sv
design/padded_integer_to_ascii.sv
tb/pita_checker.sv
tb/tb_top.sv
